// ----- rtl/sps_rca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_rca_pkg
// Shared types, codes, prime tables and resolution lookup tables for the
// sequence-level resolution, crop and aspect block.
// ----------------------------------------------------------------------------
package sps_rca_pkg;

  // Field widths
  localparam int DIM_W   = 14;
  localparam int TERM_W  = 18;
  localparam int UNITS_W = 10;
  localparam int CROP_W  = 6;
  localparam int IDC_W   = 8;
  localparam int SAR_W   = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOG2_UNIT   = 2'd0;
  localparam logic [1:0] CFG_CHROMA_FMT  = 2'd1;
  localparam logic [1:0] CFG_ASPECT_MODE = 2'd2;

  // Chroma formats
  localparam logic [3:0] CHROMA_420 = 4'd1;
  localparam logic [3:0] CHROMA_422 = 4'd2;

  // Aspect modes
  localparam logic [2:0] ASPECT_AUTO         = 3'd0;
  localparam logic [2:0] ASPECT_SQUARE       = 3'd1;
  localparam logic [2:0] ASPECT_FOUR_THREE   = 3'd2;
  localparam logic [2:0] ASPECT_SIXTEEN_NINE = 3'd3;
  localparam logic [2:0] ASPECT_NONE         = 3'd4;

  // idc codes
  localparam logic [IDC_W-1:0] IDC_NONE     = 8'd0;
  localparam logic [IDC_W-1:0] IDC_SQUARE   = 8'd1;
  localparam logic [IDC_W-1:0] IDC_EXPLICIT = 8'hff;

  // Resolution constants
  localparam logic [DIM_W-1:0] RES_160 = 14'h160;
  localparam logic [DIM_W-1:0] RES_1E0 = 14'h1e0;
  localparam logic [DIM_W-1:0] RES_210 = 14'h210;
  localparam logic [DIM_W-1:0] RES_240 = 14'h240;
  localparam logic [DIM_W-1:0] RES_280 = 14'h280;
  localparam logic [DIM_W-1:0] RES_2D0 = 14'h2d0;
  localparam logic [DIM_W-1:0] RES_3C0 = 14'h3c0;
  localparam logic [DIM_W-1:0] RES_500 = 14'h500;
  localparam logic [DIM_W-1:0] RES_5A0 = 14'h5a0;
  localparam logic [DIM_W-1:0] RES_780 = 14'h780;
  localparam logic [DIM_W-1:0] RES_F0  = 14'h0f0;
  localparam logic [DIM_W-1:0] RES_120 = 14'h120;
  localparam logic [DIM_W:0]   RES_440 = 15'h440;

  // Prime reduction: reciprocal q = (x * M) >> RECIP_SH, exact for 18-bit x
  localparam int NUM_PRIMES = 9;
  localparam int PIDX_W     = 4;
  localparam int PRIME_W    = 5;
  localparam int RECIP_W    = 23;
  localparam int RECIP_SH   = 23;

  localparam logic [PIDX_W-1:0] PIDX_LAST = 4'(NUM_PRIMES - 1);

  function automatic logic [PRIME_W-1:0] prime_at(input logic [PIDX_W-1:0] idx);
    logic [PRIME_W-1:0] p;
    case (idx)
      4'd0:    p = 5'd2;
      4'd1:    p = 5'd3;
      4'd2:    p = 5'd5;
      4'd3:    p = 5'd7;
      4'd4:    p = 5'd11;
      4'd5:    p = 5'd13;
      4'd6:    p = 5'd17;
      4'd7:    p = 5'd19;
      default: p = 5'd23;
    endcase
    return p;
  endfunction

  function automatic logic [RECIP_W-1:0] recip_at(input logic [PIDX_W-1:0] idx);
    logic [RECIP_W-1:0] m;
    case (idx)
      4'd0:    m = 23'd4194304;
      4'd1:    m = 23'd2796203;
      4'd2:    m = 23'd1677722;
      4'd3:    m = 23'd1198373;
      4'd4:    m = 23'd762601;
      4'd5:    m = 23'd645278;
      4'd6:    m = 23'd493448;
      4'd7:    m = 23'd441506;
      default: m = 23'd364723;
    endcase
    return m;
  endfunction

  // Auto table, zero when nothing matches
  function automatic logic [IDC_W-1:0] auto_table(input logic [DIM_W-1:0] w,
                                                  input logic [DIM_W-1:0] h,
                                                  input logic [DIM_W:0]   r);
    logic [IDC_W-1:0] idc;
    idc = IDC_NONE;
    case (w)
      RES_1E0: idc = (h == RES_1E0) ? 8'd7  : ((h == RES_240) ? 8'd6  : IDC_NONE);
      RES_210: idc = (h == RES_1E0) ? 8'd13 : ((h == RES_240) ? 8'd12 : IDC_NONE);
      RES_2D0: idc = (h == RES_1E0) ? 8'd5  : ((h == RES_240) ? 8'd4  : IDC_NONE);
      RES_3C0: idc = (r == RES_440) ? 8'd16 : IDC_NONE;
      RES_500: idc = (h == RES_2D0) ? 8'd1  : ((r == RES_440) ? 8'd15 : IDC_NONE);
      RES_5A0: idc = (r == RES_440) ? 8'd14 : IDC_NONE;
      RES_780: idc = (r == RES_440) ? 8'd1  : IDC_NONE;
      default: idc = IDC_NONE;
    endcase
    return idc;
  endfunction

  // Four-three table, zero when nothing matches
  function automatic logic [IDC_W-1:0] four_three_table(input logic [DIM_W-1:0] w,
                                                        input logic [DIM_W-1:0] h,
                                                        input logic [DIM_W:0]   r);
    logic [IDC_W-1:0] idc;
    idc = IDC_NONE;
    case (w)
      RES_160: begin
        if (h == RES_F0)       idc = 8'd3;
        else if (h == RES_120) idc = 8'd2;
        else if (h == RES_1E0) idc = 8'd7;
        else if (h == RES_240) idc = 8'd6;
        else                   idc = IDC_NONE;
      end
      RES_1E0: idc = (h == RES_1E0) ? 8'd11 : ((h == RES_240) ? 8'd10 : IDC_NONE);
      RES_210: idc = (h == RES_1E0) ? 8'd5  : ((h == RES_240) ? 8'd4  : IDC_NONE);
      RES_280: idc = (h == RES_1E0) ? 8'd1  : IDC_NONE;
      RES_2D0: idc = (h == RES_1E0) ? 8'd3  : ((h == RES_240) ? 8'd2  : IDC_NONE);
      RES_5A0: idc = (r == RES_440) ? 8'd1  : IDC_NONE;
      default: idc = IDC_NONE;
    endcase
    return idc;
  endfunction

  // Geometry and aspect decision for one picture size
  typedef struct packed {
    logic [UNITS_W-1:0] width_units_minus1;
    logic [UNITS_W-1:0] height_units_minus1;
    logic [CROP_W-1:0]  crop_right;
    logic [CROP_W-1:0]  crop_bottom;
    logic               crop_enable;
    logic               aspect_present;
    logic [IDC_W-1:0]   aspect_idc;
    logic               need_reduce;
    logic [TERM_W-1:0]  term_a;
    logic [TERM_W-1:0]  term_b;
  } geom_t;

  // Reduction unit status
  typedef struct packed {
    logic busy;
    logic done;
  } red_status_t;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_MUL_A,
    RD_MUL_B,
    RD_CHECK
  } red_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_RED,
    ST_HOLD
  } top_state_t;

endpackage

// ----- rtl/sps_rca_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_rca_geom
// Unit counts, right/bottom crop, table lookup and ratio terms for one
// latched picture size under the current configuration.
// ----------------------------------------------------------------------------
module sps_rca_geom (
  input  logic [sps_rca_pkg::DIM_W-1:0] pic_width,
  input  logic [sps_rca_pkg::DIM_W-1:0] pic_height,
  input  logic [2:0]                    log2_unit_size,
  input  logic [3:0]                    chroma_format,
  input  logic [2:0]                    aspect_mode,
  output sps_rca_pkg::geom_t            geom
);

  logic [7:0]  unit_m1;
  logic [14:0] w_sum, h_sum, wu, hu, w_round, h_round, pad_w, pad_h;
  logic [6:0]  crop_r_full, crop_b_full;
  logic        cx2, cy2;
  logic [14:0] h_r16_sum;
  logic [14:0] h_r16;
  logic [sps_rca_pkg::TERM_W-1:0] t16h, t9w, t4h, t3w, tw, th;
  logic [sps_rca_pkg::IDC_W-1:0]  tab_idc;
  logic        use_ratio;
  logic        present;
  logic [sps_rca_pkg::TERM_W-1:0] ra, rb;

  // Round up to whole coding units
  always_comb begin
    unit_m1 = 8'((9'd1 << log2_unit_size) - 9'd1);
    w_sum   = {1'b0, pic_width} + {7'd0, unit_m1};
    h_sum   = {1'b0, pic_height} + {7'd0, unit_m1};
    wu      = w_sum >> log2_unit_size;
    hu      = h_sum >> log2_unit_size;
    w_round = wu << log2_unit_size;
    h_round = hu << log2_unit_size;
    pad_w   = w_round - {1'b0, pic_width};
    pad_h   = h_round - {1'b0, pic_height};
  end

  // Crop in chroma units
  always_comb begin
    cx2 = (chroma_format == sps_rca_pkg::CHROMA_420) ||
          (chroma_format == sps_rca_pkg::CHROMA_422);
    cy2 = (chroma_format == sps_rca_pkg::CHROMA_420);
    crop_r_full = cx2 ? (pad_w[6:0] >> 1) : pad_w[6:0];
    crop_b_full = cy2 ? (pad_h[6:0] >> 1) : pad_h[6:0];
  end

  // Ratio terms and height rounded to 16
  always_comb begin
    h_r16_sum = {1'b0, pic_height} + 15'd15;
    h_r16     = {h_r16_sum[14:4], 4'd0};
    t16h      = {pic_height, 4'd0};
    t9w       = {1'b0, pic_width, 3'd0} + {4'd0, pic_width};
    t4h       = {2'd0, pic_height, 2'd0};
    t3w       = {3'd0, pic_width, 1'b0} + {4'd0, pic_width};
    tw        = {4'd0, pic_width};
    th        = {4'd0, pic_height};
  end

  // Aspect mode decision
  always_comb begin
    present   = 1'b1;
    tab_idc   = sps_rca_pkg::IDC_NONE;
    use_ratio = 1'b0;
    ra        = t4h;
    rb        = t3w;
    case (aspect_mode)
      sps_rca_pkg::ASPECT_NONE: begin
        present = 1'b0;
      end
      sps_rca_pkg::ASPECT_SQUARE: begin
        tab_idc = sps_rca_pkg::IDC_SQUARE;
      end
      sps_rca_pkg::ASPECT_AUTO: begin
        tab_idc   = sps_rca_pkg::auto_table(pic_width, pic_height, h_r16);
        use_ratio = (tab_idc == sps_rca_pkg::IDC_NONE);
        ra        = t16h;
        rb        = t9w;
      end
      sps_rca_pkg::ASPECT_FOUR_THREE: begin
        tab_idc   = sps_rca_pkg::four_three_table(pic_width, pic_height, h_r16);
        use_ratio = (tab_idc == sps_rca_pkg::IDC_NONE);
      end
      sps_rca_pkg::ASPECT_SIXTEEN_NINE: begin
        if (pic_width == sps_rca_pkg::RES_160) begin
          tab_idc = (pic_height == sps_rca_pkg::RES_1E0) ? 8'd8 :
                    ((pic_height == sps_rca_pkg::RES_240) ? 8'd9 : sps_rca_pkg::IDC_NONE);
        end else begin
          tab_idc = sps_rca_pkg::auto_table(pic_width, pic_height, h_r16);
        end
        use_ratio = (tab_idc == sps_rca_pkg::IDC_NONE);
      end
      default: begin
        use_ratio = 1'b1;
        ra        = th;
        rb        = tw;
      end
    endcase
  end

  // Pack results
  always_comb begin
    geom.width_units_minus1  = 10'(wu - 15'd1);
    geom.height_units_minus1 = 10'(hu - 15'd1);
    geom.crop_right          = crop_r_full[5:0];
    geom.crop_bottom         = crop_b_full[5:0];
    geom.crop_enable         = (crop_r_full != 7'd0) || (crop_b_full != 7'd0);
    geom.aspect_present      = present;
    geom.term_a              = ra;
    geom.term_b              = rb;
    geom.need_reduce         = use_ratio && (ra != rb);
    if (!use_ratio) begin
      geom.aspect_idc = tab_idc;
    end else if (ra == rb) begin
      geom.aspect_idc = sps_rca_pkg::IDC_SQUARE;
    end else begin
      geom.aspect_idc = sps_rca_pkg::IDC_EXPLICIT;
    end
  end

endmodule

// ----- rtl/sps_rca_reduce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_rca_reduce
// Iterative ratio reduction by the primes 2 to 23: one shared reciprocal
// multiplier computes quotients for both terms, then a check step divides
// while both are divisible.
// ----------------------------------------------------------------------------
module sps_rca_reduce (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sps_rca_pkg::TERM_W-1:0] a_in,
  input  logic [sps_rca_pkg::TERM_W-1:0] b_in,
  output logic [sps_rca_pkg::TERM_W-1:0] a_out,
  output logic [sps_rca_pkg::TERM_W-1:0] b_out,
  output sps_rca_pkg::red_status_t       status
);

  localparam int PROD_W = sps_rca_pkg::TERM_W + sps_rca_pkg::RECIP_W;
  localparam int CHK_W  = sps_rca_pkg::TERM_W + sps_rca_pkg::PRIME_W;

  sps_rca_pkg::red_state_t state_r, state_nxt;
  logic [sps_rca_pkg::PIDX_W-1:0] pidx_r, pidx_nxt;
  logic [sps_rca_pkg::TERM_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [sps_rca_pkg::TERM_W-1:0] qa_r, qa_nxt, qb_r, qb_nxt;

  logic [sps_rca_pkg::TERM_W-1:0]  mul_op;
  logic [PROD_W-1:0]               prod;
  logic [sps_rca_pkg::TERM_W-1:0]  quot;
  logic [sps_rca_pkg::PRIME_W-1:0] prime;
  logic [CHK_W-1:0]                back_a, back_b;
  logic                            divisible;

  // Shared reciprocal multiplier
  always_comb begin
    mul_op = (state_r == sps_rca_pkg::RD_MUL_B) ? b_r : a_r;
    prod   = {{sps_rca_pkg::RECIP_W{1'b0}}, mul_op} *
             {{sps_rca_pkg::TERM_W{1'b0}}, sps_rca_pkg::recip_at(pidx_r)};
    quot   = prod[sps_rca_pkg::RECIP_SH +: sps_rca_pkg::TERM_W];
  end

  // Divisibility check on registered quotients
  always_comb begin
    prime     = sps_rca_pkg::prime_at(pidx_r);
    back_a    = CHK_W'(qa_r) * CHK_W'(prime);
    back_b    = CHK_W'(qb_r) * CHK_W'(prime);
    divisible = (back_a == CHK_W'(a_r)) && (back_b == CHK_W'(b_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sps_rca_pkg::RD_IDLE;
      pidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    qa_r <= qa_nxt;
    qb_r <= qb_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    pidx_nxt    = pidx_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    qa_nxt      = qa_r;
    qb_nxt      = qb_r;
    status.busy = (state_r != sps_rca_pkg::RD_IDLE);
    status.done = 1'b0;
    case (state_r)
      sps_rca_pkg::RD_IDLE: begin
        if (start) begin
          a_nxt     = a_in;
          b_nxt     = b_in;
          pidx_nxt  = '0;
          state_nxt = sps_rca_pkg::RD_MUL_A;
        end
      end
      sps_rca_pkg::RD_MUL_A: begin
        qa_nxt    = quot;
        state_nxt = sps_rca_pkg::RD_MUL_B;
      end
      sps_rca_pkg::RD_MUL_B: begin
        qb_nxt    = quot;
        state_nxt = sps_rca_pkg::RD_CHECK;
      end
      sps_rca_pkg::RD_CHECK: begin
        if (divisible) begin
          a_nxt     = qa_r;
          b_nxt     = qb_r;
          state_nxt = sps_rca_pkg::RD_MUL_A;
        end else if (pidx_r == sps_rca_pkg::PIDX_LAST) begin
          status.done = 1'b1;
          state_nxt   = sps_rca_pkg::RD_IDLE;
        end else begin
          pidx_nxt  = pidx_r + 4'd1;
          state_nxt = sps_rca_pkg::RD_MUL_A;
        end
      end
      default: begin
        state_nxt = sps_rca_pkg::RD_IDLE;
      end
    endcase
  end

  assign a_out = a_r;
  assign b_out = b_r;

endmodule

// ----- rtl/sps_resolution_crop_and_aspect.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_resolution_crop_and_aspect
// Sequence-level coded size, right/bottom crop and aspect ratio fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one picture size per item. The result channel
//   out_valid/out_stall carries one result item per input. Configuration writes (cfg_we,
//   cfg_index, cfg_wdata) must be made while idle; the block does not enforce this.
// Flow: the accepted size is decoded in ST_CALC; when the aspect fields come
//   from a table or need no reduction, the result is loaded from ST_CALC. An
//   explicit ratio goes through the shared reciprocal multiplier in RD_MUL_A,
//   RD_MUL_B and RD_CHECK per trial division, one trial per prime (9 primes)
//   plus one per successful division (at most 17 for 18-bit terms); the divider loop sets the rate.
// Throughput: one item at a time; in_stall is high from accept until the
//   result is loaded into the output register. A new item is accepted while
//   the previous result still waits in the output register.
// Reset: synchronous, active low; registers return to log2_unit_size 4,
//   chroma_format 1, aspect_mode 0, and no result is pending.
// Stall: a stalled result holds; a finished item waits until the output
//   register frees up.
// ----------------------------------------------------------------------------
module sps_resolution_crop_and_aspect (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [3:0]                      cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sps_rca_pkg::DIM_W-1:0]   in_pic_width,
  input  logic [sps_rca_pkg::DIM_W-1:0]   in_pic_height,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sps_rca_pkg::UNITS_W-1:0] out_width_units_minus1,
  output logic [sps_rca_pkg::UNITS_W-1:0] out_height_units_minus1,
  output logic [sps_rca_pkg::CROP_W-1:0]  out_crop_right,
  output logic [sps_rca_pkg::CROP_W-1:0]  out_crop_bottom,
  output logic                            out_crop_enable,
  output logic                            out_aspect_present,
  output logic [sps_rca_pkg::IDC_W-1:0]   out_aspect_idc,
  output logic [sps_rca_pkg::SAR_W-1:0]   out_sar_width,
  output logic [sps_rca_pkg::SAR_W-1:0]   out_sar_height
);

  // Configuration registers
  logic [2:0] log2_unit_r;
  logic [3:0] chroma_fmt_r;
  logic [2:0] aspect_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_unit_r   <= 3'd4;
      chroma_fmt_r  <= 4'd1;
      aspect_mode_r <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sps_rca_pkg::CFG_LOG2_UNIT:   log2_unit_r   <= cfg_wdata[2:0];
        sps_rca_pkg::CFG_CHROMA_FMT:  chroma_fmt_r  <= cfg_wdata;
        sps_rca_pkg::CFG_ASPECT_MODE: aspect_mode_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Latched input item
  sps_rca_pkg::top_state_t state_r, state_nxt;
  logic [sps_rca_pkg::DIM_W-1:0] width_r, height_r;
  logic in_accept;

  assign in_stall  = (state_r != sps_rca_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      width_r  <= in_pic_width;
      height_r <= in_pic_height;
    end
  end

  // Geometry and aspect decision
  sps_rca_pkg::geom_t geom;

  sps_rca_geom u_geom (
    .pic_width      (width_r),
    .pic_height     (height_r),
    .log2_unit_size (log2_unit_r),
    .chroma_format  (chroma_fmt_r),
    .aspect_mode    (aspect_mode_r),
    .geom           (geom)
  );

  // Ratio reduction unit
  logic red_start;
  logic [sps_rca_pkg::TERM_W-1:0] red_a, red_b;
  sps_rca_pkg::red_status_t red_status;

  sps_rca_reduce u_reduce (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (red_start),
    .a_in   (geom.term_a),
    .b_in   (geom.term_b),
    .a_out  (red_a),
    .b_out  (red_b),
    .status (red_status)
  );

  // Output register
  logic out_valid_r, out_valid_nxt;
  logic out_free, load_out, result_ready;
  logic [sps_rca_pkg::UNITS_W-1:0] out_wu_r, out_hu_r;
  logic [sps_rca_pkg::CROP_W-1:0]  out_cr_r, out_cb_r;
  logic                            out_ce_r, out_ap_r;
  logic [sps_rca_pkg::IDC_W-1:0]   out_idc_r;
  logic [sps_rca_pkg::SAR_W-1:0]   out_sw_r, out_sh_r;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sps_rca_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_wu_r  <= geom.width_units_minus1;
      out_hu_r  <= geom.height_units_minus1;
      out_cr_r  <= geom.crop_right;
      out_cb_r  <= geom.crop_bottom;
      out_ce_r  <= geom.crop_enable;
      out_ap_r  <= geom.aspect_present;
      out_idc_r <= geom.aspect_idc;
      out_sw_r  <= geom.need_reduce ? red_a[sps_rca_pkg::SAR_W-1:0] : '0;
      out_sh_r  <= geom.need_reduce ? red_b[sps_rca_pkg::SAR_W-1:0] : '0;
    end
  end

  // Control sequencer
  always_comb begin
    state_nxt    = state_r;
    red_start    = 1'b0;
    result_ready = 1'b0;
    case (state_r)
      sps_rca_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = sps_rca_pkg::ST_CALC;
      end
      sps_rca_pkg::ST_CALC: begin
        if (geom.need_reduce) begin
          red_start = 1'b1;
          state_nxt = sps_rca_pkg::ST_RED;
        end else begin
          result_ready = 1'b1;
        end
      end
      sps_rca_pkg::ST_RED: begin
        result_ready = red_status.done;
      end
      sps_rca_pkg::ST_HOLD: begin
        result_ready = 1'b1;
      end
      default: begin
        state_nxt = sps_rca_pkg::ST_IDLE;
      end
    endcase
    load_out = result_ready && out_free;
    if (result_ready) begin
      state_nxt = out_free ? sps_rca_pkg::ST_IDLE : sps_rca_pkg::ST_HOLD;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_width_units_minus1  = out_wu_r;
  assign out_height_units_minus1 = out_hu_r;
  assign out_crop_right          = out_cr_r;
  assign out_crop_bottom         = out_cb_r;
  assign out_crop_enable         = out_ce_r;
  assign out_aspect_present      = out_ap_r;
  assign out_aspect_idc          = out_idc_r;
  assign out_sar_width           = out_sw_r;
  assign out_sar_height          = out_sh_r;

endmodule
